// ===== rtl/block_table_first_fit_allocator_core_macros.svh =====
// Assertion macros for the block-table allocator checker.
// No dependencies; included by the checker file only.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define BTFFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BTFFA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/btffa_pkg.sv =====
// Shared constants, codes and types of the block-table allocator.
// No dependencies; used by every RTL module of the block.
package btffa_pkg;

    localparam int TABLE_BLOCKS = 1024;
    localparam int BLOCK_BYTES  = 4096;
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
    localparam int IDX_W        = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam int CNT_W        = $clog2(TABLE_BLOCKS + 1);

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int ACT_W     = 11;
    localparam int STAT_W    = 2;
    localparam int KIND_W    = 2;
    localparam int COPY_W    = 23;
    localparam int CNT_OUT_W = 11;
    localparam int BASE_HI_W = ADDR_W - BLOCK_SHIFT;
    localparam int NEED_W    = SIZE_W + 1 - BLOCK_SHIFT;

    // table entry bits
    localparam int ENT_TAKEN = 0;
    localparam int ENT_FIRST = 1;
    localparam int ENT_NEXT  = 2;
    typedef logic [2:0] t_ent;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

    // configuration register indexes
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_ACTIVE    = 1'b1;

    typedef enum logic [4:0] {
        S_CLR_INIT, S_CLR, S_IDLE, S_DISPATCH, S_DEC, S_DEC_CHK,
        S_CL_CHK, S_CL_EV, S_RESIZE, S_SHR_INIT,
        S_FC_CHK, S_FC_EV, S_FC_END, S_RMW_RD, S_RMW_WR,
        S_GR_INIT, S_GR_CHK, S_GR_EV, S_GR_WR, S_HEAD_PTR,
        S_FR_INIT, S_FR_CHK, S_FR_EV, S_MK_INIT, S_MK_WR, S_MV_INIT,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR_INIT, OP_CLR, OP_LATCH, OP_DEC_RD,
        OP_FAIL_NOMEM, OP_FAIL_ADDR, OP_RD, OP_INC,
        OP_FR_INIT, OP_FR_EV, OP_MK_INIT, OP_MK_WR,
        OP_FC_AT_BLK, OP_FC_AT_TAIL, OP_FC_EV, OP_MOVE_INFO,
        OP_CL_INIT, OP_CL_EV, OP_RES_ADDR, OP_GR_INIT, OP_GR_WR,
        OP_TAIL_PTR, OP_HEAD_PTR, OP_CLR_NEXT, OP_SET_NEXT, OP_PUBLISH
    } t_op;

    typedef enum logic [2:0] {
        JOB_ALLOC, JOB_FREE, JOB_SHRINK, JOB_GROW, JOB_MOVE
    } t_job;

    typedef struct packed {
        t_op op;
    } t_ctl_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic size_zero;
        logic oversize;
        logic addr_zero;
        logic dec_pre_ok;
        logic ent_head;
        logic ent_taken;
        logic chain_end;
        logic ptr_end;
        logic run_hit;
        logic clr_last;
        logic mark_last;
        logic cur_ge_want;
        logic cur_gt_want;
        logic grow_oob;
        logic grow_scan_end;
        logic grow_last;
        logic out_busy;
        logic cfg_reinit;
    } t_dp_stat;

endpackage

// ===== rtl/btffa_datapath.sv =====
// Datapath of the allocator: block table memory, walk pointers, counters,
// configuration and result registers. Depends on btffa_pkg.
module btffa_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  btffa_pkg::t_ctl_cmd                i_cmd,
    output btffa_pkg::t_dp_stat                o_stat,
    input  logic [btffa_pkg::KIND_W-1:0]       i_kind,
    input  logic [btffa_pkg::SIZE_W-1:0]       i_size_bytes,
    input  logic [btffa_pkg::ADDR_W-1:0]       i_address,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [btffa_pkg::STAT_W-1:0]       o_status,
    output logic [btffa_pkg::ADDR_W-1:0]       o_result_address,
    output logic                               o_copy_needed,
    output logic [btffa_pkg::COPY_W-1:0]       o_copy_bytes,
    output logic [btffa_pkg::CNT_OUT_W-1:0]    o_taken_blocks,
    output logic [btffa_pkg::CNT_OUT_W-1:0]    o_spare_blocks,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_index,
    input  logic [btffa_pkg::ADDR_W-1:0]       i_cfg_data
);

    localparam int CW = btffa_pkg::CNT_W;
    localparam int SW = btffa_pkg::BLOCK_SHIFT;
    localparam int SIZE_W_P1 = btffa_pkg::SIZE_W + 1;

    btffa_pkg::t_ent mem [btffa_pkg::TABLE_BLOCKS];

    logic [btffa_pkg::BASE_HI_W-1:0] r_base_hi;
    logic [btffa_pkg::ACT_W-1:0]     r_active;
    logic [CW-1:0]                   r_taken, r_free;
    logic [btffa_pkg::KIND_W-1:0]    r_kind;
    logic                            r_size_zero, r_addr_zero;
    logic [btffa_pkg::NEED_W-1:0]    r_need;
    logic [btffa_pkg::ADDR_W-1:0]    r_addr;
    logic [btffa_pkg::IDX_W-1:0]     r_blk, r_start, r_first;
    logic [CW-1:0]                   r_ptr, r_run, r_cnt, r_cur;
    btffa_pkg::t_ent                 r_rdata;
    logic [btffa_pkg::STAT_W-1:0]    r_status;
    logic [btffa_pkg::ADDR_W-1:0]    r_res;
    logic                            r_copy;
    logic [btffa_pkg::COPY_W-1:0]    r_copy_bytes;
    logic                            r_out_valid;
    logic [btffa_pkg::STAT_W-1:0]    r_o_status;
    logic [btffa_pkg::ADDR_W-1:0]    r_o_addr;
    logic                            r_o_copy;
    logic [btffa_pkg::COPY_W-1:0]    r_o_copy_bytes;
    logic [CW-1:0]                   r_o_taken, r_o_spare;

    logic [CW-1:0]                      live, want;
    logic [SIZE_W_P1-1:0]               need_sum;
    logic [btffa_pkg::ADDR_W-1:0]       off;
    logic [btffa_pkg::BASE_HI_W-1:0]    dec_b;
    logic [CW:0]                        blk_want, blk_cur, ptr_ext;
    logic [CW-1:0]                      run_inc, cnt_inc;
    logic                               mem_we, mem_re;
    btffa_pkg::t_ent                    mem_wdata;
    logic [btffa_pkg::IDX_W-1:0]        mem_raddr;
    btffa_pkg::t_op                     op;

    assign op = i_cmd.op;

    // live table size: register value clipped to the table depth
    assign live = (r_active > btffa_pkg::ACT_W'(btffa_pkg::TABLE_BLOCKS))
                ? CW'(btffa_pkg::TABLE_BLOCKS) : CW'(r_active);
    assign need_sum = {1'b0, i_size_bytes} + SIZE_W_P1'(btffa_pkg::BLOCK_BYTES - 1);
    assign want     = r_need[CW-1:0];
    assign off      = r_addr - {r_base_hi, SW'(0)};
    assign dec_b    = off[btffa_pkg::ADDR_W-1:SW];
    assign blk_want = (CW+1)'(r_blk) + (CW+1)'(want);
    assign blk_cur  = (CW+1)'(r_blk) + (CW+1)'(r_cur);
    assign ptr_ext  = (CW+1)'(r_ptr);
    assign run_inc  = r_run + CW'(1);
    assign cnt_inc  = r_cnt + CW'(1);

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.size_zero     = r_size_zero;
        o_stat.oversize      = r_need > btffa_pkg::NEED_W'(live);
        o_stat.addr_zero     = r_addr_zero;
        o_stat.dec_pre_ok    = (off[SW-1:0] == '0)
                               && (dec_b < btffa_pkg::BASE_HI_W'(live));
        o_stat.ent_head      = r_rdata[btffa_pkg::ENT_TAKEN] && r_rdata[btffa_pkg::ENT_FIRST];
        o_stat.ent_taken     = r_rdata[btffa_pkg::ENT_TAKEN];
        o_stat.chain_end     = !r_rdata[btffa_pkg::ENT_NEXT];
        o_stat.ptr_end       = r_ptr >= live;
        o_stat.run_hit       = !r_rdata[btffa_pkg::ENT_TAKEN] && (run_inc == want);
        o_stat.clr_last      = r_ptr == CW'(btffa_pkg::TABLE_BLOCKS - 1);
        o_stat.mark_last     = cnt_inc == want;
        o_stat.cur_ge_want   = r_cur >= want;
        o_stat.cur_gt_want   = r_cur > want;
        o_stat.grow_oob      = blk_want > (CW+1)'(live);
        o_stat.grow_scan_end = ptr_ext == blk_want;
        o_stat.grow_last     = ptr_ext + (CW+1)'(1) == blk_want;
        o_stat.out_busy      = r_out_valid && i_out_stall;
        o_stat.cfg_reinit    = i_cfg_valid && (i_cfg_index == btffa_pkg::CFG_ACTIVE);
    end

    // table write and read port controls
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_re    = (op == btffa_pkg::OP_RD) || (op == btffa_pkg::OP_DEC_RD);
        mem_raddr = (op == btffa_pkg::OP_DEC_RD) ? dec_b[btffa_pkg::IDX_W-1:0]
                                                  : r_ptr[btffa_pkg::IDX_W-1:0];
        unique case (op)
            btffa_pkg::OP_CLR, btffa_pkg::OP_FC_EV: begin
                mem_we = 1'b1;
            end
            btffa_pkg::OP_MK_WR: begin
                mem_we = 1'b1;
                mem_wdata[btffa_pkg::ENT_TAKEN] = 1'b1;
                mem_wdata[btffa_pkg::ENT_FIRST] = (r_cnt == '0);
                mem_wdata[btffa_pkg::ENT_NEXT]  = !o_stat.mark_last;
            end
            btffa_pkg::OP_GR_WR: begin
                mem_we = 1'b1;
                mem_wdata[btffa_pkg::ENT_TAKEN] = 1'b1;
                mem_wdata[btffa_pkg::ENT_NEXT]  = !o_stat.grow_last;
            end
            btffa_pkg::OP_CLR_NEXT: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                mem_wdata[btffa_pkg::ENT_NEXT] = 1'b0;
            end
            btffa_pkg::OP_SET_NEXT: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                mem_wdata[btffa_pkg::ENT_NEXT] = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_ptr[btffa_pkg::IDX_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_hi <= '0;
            r_active  <= btffa_pkg::ACT_W'(btffa_pkg::TABLE_BLOCKS);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == btffa_pkg::CFG_HEAP_BASE) begin
                r_base_hi <= i_cfg_data[btffa_pkg::ADDR_W-1:SW];
            end else begin
                r_active <= i_cfg_data[btffa_pkg::ACT_W-1:0];
            end
        end
    end

    // counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_free      <= CW'(btffa_pkg::TABLE_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            // publish only happens once the previous result is gone
            if (op == btffa_pkg::OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (op)
                btffa_pkg::OP_CLR_INIT: begin
                    r_taken <= '0;
                    r_free  <= live;
                end
                btffa_pkg::OP_MK_WR, btffa_pkg::OP_GR_WR: begin
                    r_taken <= r_taken + CW'(1);
                    r_free  <= r_free - CW'(1);
                end
                btffa_pkg::OP_FC_EV: begin
                    r_taken <= r_taken - CW'(1);
                    r_free  <= r_free + CW'(1);
                end
                default: begin
                    r_taken <= r_taken;
                end
            endcase
        end
    end

    // walk pointers, request registers and output registers
    always_ff @(posedge i_clk) begin
        unique case (op)
            btffa_pkg::OP_CLR_INIT, btffa_pkg::OP_FR_INIT: begin
                r_ptr <= '0;
                r_run <= '0;
            end
            btffa_pkg::OP_CLR, btffa_pkg::OP_RD, btffa_pkg::OP_DEC_RD: begin
                if (op == btffa_pkg::OP_CLR) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                if (op == btffa_pkg::OP_DEC_RD) begin
                    r_blk <= dec_b[btffa_pkg::IDX_W-1:0];
                end
            end
            btffa_pkg::OP_LATCH: begin
                r_kind       <= i_kind;
                r_size_zero  <= (i_size_bytes == '0);
                r_need       <= need_sum[SIZE_W_P1-1:SW];
                r_addr       <= i_address;
                r_addr_zero  <= (i_address == '0);
                r_status     <= btffa_pkg::ST_OK;
                r_res        <= '0;
                r_copy       <= 1'b0;
                r_copy_bytes <= '0;
            end
            btffa_pkg::OP_FAIL_NOMEM: r_status <= btffa_pkg::ST_NOMEM;
            btffa_pkg::OP_FAIL_ADDR:  r_status <= btffa_pkg::ST_BAD_ADDR;
            btffa_pkg::OP_INC:        r_ptr <= r_ptr + CW'(1);
            btffa_pkg::OP_FR_EV: begin
                if (r_rdata[btffa_pkg::ENT_TAKEN]) begin
                    r_run <= '0;
                end else begin
                    if (r_run == '0) begin
                        r_first <= r_ptr[btffa_pkg::IDX_W-1:0];
                    end
                    r_run <= run_inc;
                    if (o_stat.run_hit) begin
                        r_start <= (r_run == '0) ? r_ptr[btffa_pkg::IDX_W-1:0] : r_first;
                    end
                end
                r_ptr <= r_ptr + CW'(1);
            end
            btffa_pkg::OP_MK_INIT: begin
                r_ptr <= CW'(r_start);
                r_cnt <= '0;
                r_res <= {r_base_hi + btffa_pkg::BASE_HI_W'(r_start), SW'(0)};
            end
            btffa_pkg::OP_MK_WR: begin
                r_ptr <= r_ptr + CW'(1);
                r_cnt <= cnt_inc;
            end
            btffa_pkg::OP_FC_AT_BLK: r_ptr <= CW'(r_blk);
            btffa_pkg::OP_FC_AT_TAIL: r_ptr <= blk_want[CW-1:0];
            btffa_pkg::OP_FC_EV:      r_ptr <= r_ptr + CW'(1);
            btffa_pkg::OP_MOVE_INFO: begin
                r_ptr        <= CW'(r_blk);
                r_copy       <= 1'b1;
                r_copy_bytes <= btffa_pkg::COPY_W'({r_cur, SW'(0)});
            end
            btffa_pkg::OP_CL_INIT: begin
                r_ptr <= CW'(r_blk);
                r_cur <= '0;
            end
            btffa_pkg::OP_CL_EV: begin
                if (r_rdata[btffa_pkg::ENT_TAKEN]) begin
                    r_cur <= r_cur + CW'(1);
                end
                r_ptr <= r_ptr + CW'(1);
            end
            btffa_pkg::OP_RES_ADDR: r_res <= r_addr;
            btffa_pkg::OP_GR_INIT:  r_ptr <= blk_cur[CW-1:0];
            btffa_pkg::OP_GR_WR:    r_ptr <= r_ptr + CW'(1);
            btffa_pkg::OP_TAIL_PTR: r_ptr <= blk_want[CW-1:0] - CW'(1);
            btffa_pkg::OP_HEAD_PTR: begin
                r_ptr <= blk_cur[CW-1:0] - CW'(1);
                r_res <= r_addr;
            end
            btffa_pkg::OP_PUBLISH: begin
                r_o_status     <= r_status;
                r_o_addr       <= (r_status == btffa_pkg::ST_OK) ? r_res : '0;
                r_o_copy       <= r_copy;
                r_o_copy_bytes <= r_copy_bytes;
                r_o_taken      <= r_taken;
                r_o_spare      <= r_free;
            end
            default: begin
                r_ptr <= r_ptr;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_result_address = r_o_addr;
    assign o_copy_needed    = r_o_copy;
    assign o_copy_bytes     = r_o_copy_bytes;
    assign o_taken_blocks   = btffa_pkg::CNT_OUT_W'(r_o_taken);
    assign o_spare_blocks   = btffa_pkg::CNT_OUT_W'(r_o_spare);

endmodule

// ===== rtl/btffa_ctrl.sv =====
// Controller of the allocator: sequences table walks through the datapath.
// Depends on btffa_pkg.
module btffa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  btffa_pkg::t_dp_stat i_stat,
    output btffa_pkg::t_ctl_cmd o_cmd
);

    btffa_pkg::t_state r_state, n_state;
    btffa_pkg::t_job   r_job, n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btffa_pkg::S_CLR_INIT;
            r_job   <= btffa_pkg::JOB_ALLOC;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    assign o_in_stall = (r_state != btffa_pkg::S_IDLE) || i_stat.cfg_reinit;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        o_cmd.op = btffa_pkg::OP_NONE;
        unique case (r_state)
            btffa_pkg::S_CLR_INIT: begin
                o_cmd.op = btffa_pkg::OP_CLR_INIT;
                n_state  = btffa_pkg::S_CLR;
            end
            btffa_pkg::S_CLR: begin
                o_cmd.op = btffa_pkg::OP_CLR;
                if (i_stat.clr_last) n_state = btffa_pkg::S_IDLE;
            end
            btffa_pkg::S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.op = btffa_pkg::OP_LATCH;
                    n_state  = btffa_pkg::S_DISPATCH;
                end
            end
            btffa_pkg::S_DISPATCH: begin
                if (i_stat.kind == btffa_pkg::KIND_ALLOC
                    || (i_stat.kind == btffa_pkg::KIND_RESIZE && i_stat.addr_zero)) begin
                    n_job = btffa_pkg::JOB_ALLOC;
                    if (i_stat.size_zero || i_stat.oversize) begin
                        o_cmd.op = btffa_pkg::OP_FAIL_NOMEM;
                        n_state  = btffa_pkg::S_DONE;
                    end else begin
                        n_state = btffa_pkg::S_FR_INIT;
                    end
                end else if (i_stat.kind == btffa_pkg::KIND_FREE
                             || i_stat.kind == btffa_pkg::KIND_RESIZE) begin
                    n_job   = btffa_pkg::JOB_FREE;
                    n_state = btffa_pkg::S_DEC;
                end else begin
                    o_cmd.op = btffa_pkg::OP_FAIL_NOMEM;
                    n_state  = btffa_pkg::S_DONE;
                end
            end
            btffa_pkg::S_DEC: begin
                if (i_stat.dec_pre_ok) begin
                    o_cmd.op = btffa_pkg::OP_DEC_RD;
                    n_state  = btffa_pkg::S_DEC_CHK;
                end else begin
                    o_cmd.op = btffa_pkg::OP_FAIL_ADDR;
                    n_state  = btffa_pkg::S_DONE;
                end
            end
            btffa_pkg::S_DEC_CHK: begin
                priority if (!i_stat.ent_head) begin
                    o_cmd.op = btffa_pkg::OP_FAIL_ADDR;
                    n_state  = btffa_pkg::S_DONE;
                end else if (i_stat.kind == btffa_pkg::KIND_FREE) begin
                    o_cmd.op = btffa_pkg::OP_FC_AT_BLK;
                    n_state  = btffa_pkg::S_FC_CHK;
                end else if (i_stat.size_zero || i_stat.oversize) begin
                    o_cmd.op = btffa_pkg::OP_FAIL_NOMEM;
                    n_state  = btffa_pkg::S_DONE;
                end else begin
                    o_cmd.op = btffa_pkg::OP_CL_INIT;
                    n_state  = btffa_pkg::S_CL_CHK;
                end
            end
            btffa_pkg::S_CL_CHK: begin
                if (i_stat.ptr_end) begin
                    n_state = btffa_pkg::S_RESIZE;
                end else begin
                    o_cmd.op = btffa_pkg::OP_RD;
                    n_state  = btffa_pkg::S_CL_EV;
                end
            end
            btffa_pkg::S_CL_EV: begin
                o_cmd.op = btffa_pkg::OP_CL_EV;
                n_state  = i_stat.chain_end ? btffa_pkg::S_RESIZE : btffa_pkg::S_CL_CHK;
            end
            btffa_pkg::S_RESIZE: begin
                priority if (i_stat.cur_gt_want) begin
                    o_cmd.op = btffa_pkg::OP_RES_ADDR;
                    n_job    = btffa_pkg::JOB_SHRINK;
                    n_state  = btffa_pkg::S_SHR_INIT;
                end else if (i_stat.cur_ge_want) begin
                    o_cmd.op = btffa_pkg::OP_RES_ADDR;
                    n_state  = btffa_pkg::S_DONE;
                end else if (i_stat.grow_oob) begin
                    n_job   = btffa_pkg::JOB_MOVE;
                    n_state = btffa_pkg::S_FR_INIT;
                end else begin
                    n_job   = btffa_pkg::JOB_GROW;
                    n_state = btffa_pkg::S_GR_INIT;
                end
            end
            btffa_pkg::S_SHR_INIT: begin
                o_cmd.op = btffa_pkg::OP_FC_AT_TAIL;
                n_state  = btffa_pkg::S_FC_CHK;
            end
            btffa_pkg::S_FC_CHK: begin
                if (i_stat.ptr_end) begin
                    n_state = btffa_pkg::S_FC_END;
                end else begin
                    o_cmd.op = btffa_pkg::OP_RD;
                    n_state  = btffa_pkg::S_FC_EV;
                end
            end
            btffa_pkg::S_FC_EV: begin
                o_cmd.op = btffa_pkg::OP_FC_EV;
                n_state  = i_stat.chain_end ? btffa_pkg::S_FC_END : btffa_pkg::S_FC_CHK;
            end
            btffa_pkg::S_FC_END: begin
                if (r_job == btffa_pkg::JOB_SHRINK) begin
                    o_cmd.op = btffa_pkg::OP_TAIL_PTR;
                    n_state  = btffa_pkg::S_RMW_RD;
                end else begin
                    n_state = btffa_pkg::S_DONE;
                end
            end
            btffa_pkg::S_RMW_RD: begin
                o_cmd.op = btffa_pkg::OP_RD;
                n_state  = btffa_pkg::S_RMW_WR;
            end
            btffa_pkg::S_RMW_WR: begin
                o_cmd.op = (r_job == btffa_pkg::JOB_SHRINK) ? btffa_pkg::OP_CLR_NEXT
                                                             : btffa_pkg::OP_SET_NEXT;
                n_state  = btffa_pkg::S_DONE;
            end
            btffa_pkg::S_GR_INIT: begin
                o_cmd.op = btffa_pkg::OP_GR_INIT;
                n_state  = btffa_pkg::S_GR_CHK;
            end
            btffa_pkg::S_GR_CHK: begin
                if (i_stat.grow_scan_end) begin
                    o_cmd.op = btffa_pkg::OP_GR_INIT;
                    n_state  = btffa_pkg::S_GR_WR;
                end else begin
                    o_cmd.op = btffa_pkg::OP_RD;
                    n_state  = btffa_pkg::S_GR_EV;
                end
            end
            btffa_pkg::S_GR_EV: begin
                if (i_stat.ent_taken) begin
                    n_job   = btffa_pkg::JOB_MOVE;
                    n_state = btffa_pkg::S_FR_INIT;
                end else begin
                    o_cmd.op = btffa_pkg::OP_INC;
                    n_state  = btffa_pkg::S_GR_CHK;
                end
            end
            btffa_pkg::S_GR_WR: begin
                o_cmd.op = btffa_pkg::OP_GR_WR;
                if (i_stat.grow_last) n_state = btffa_pkg::S_HEAD_PTR;
            end
            btffa_pkg::S_HEAD_PTR: begin
                o_cmd.op = btffa_pkg::OP_HEAD_PTR;
                n_state  = btffa_pkg::S_RMW_RD;
            end
            btffa_pkg::S_FR_INIT: begin
                o_cmd.op = btffa_pkg::OP_FR_INIT;
                n_state  = btffa_pkg::S_FR_CHK;
            end
            btffa_pkg::S_FR_CHK: begin
                if (i_stat.ptr_end) begin
                    o_cmd.op = btffa_pkg::OP_FAIL_NOMEM;
                    n_state  = btffa_pkg::S_DONE;
                end else begin
                    o_cmd.op = btffa_pkg::OP_RD;
                    n_state  = btffa_pkg::S_FR_EV;
                end
            end
            btffa_pkg::S_FR_EV: begin
                o_cmd.op = btffa_pkg::OP_FR_EV;
                n_state  = i_stat.run_hit ? btffa_pkg::S_MK_INIT : btffa_pkg::S_FR_CHK;
            end
            btffa_pkg::S_MK_INIT: begin
                o_cmd.op = btffa_pkg::OP_MK_INIT;
                n_state  = btffa_pkg::S_MK_WR;
            end
            btffa_pkg::S_MK_WR: begin
                o_cmd.op = btffa_pkg::OP_MK_WR;
                if (i_stat.mark_last) begin
                    n_state = (r_job == btffa_pkg::JOB_MOVE) ? btffa_pkg::S_MV_INIT
                                                             : btffa_pkg::S_DONE;
                end
            end
            btffa_pkg::S_MV_INIT: begin
                o_cmd.op = btffa_pkg::OP_MOVE_INFO;
                n_state  = btffa_pkg::S_FC_CHK;
            end
            btffa_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = btffa_pkg::OP_PUBLISH;
                    n_state  = btffa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btffa_pkg::S_CLR_INIT;
            end
        endcase
        // a new active block count restarts the table from scratch
        if (i_stat.cfg_reinit) begin
            n_state  = btffa_pkg::S_CLR_INIT;
            o_cmd.op = btffa_pkg::OP_NONE;
        end
    end

endmodule

// ===== rtl/block_table_first_fit_allocator_core.sv =====
// Channel   | Direction | Signals                                   | Transaction on
// request   | in        | i_in_valid/o_in_stall, kind, size, addr   | valid & !stall
// result    | out       | o_out_valid/i_out_stall, status..spare    | valid & !stall
// config    | in        | i_cfg_valid/o_cfg_ready, index, data      | valid & ready
//
// One request at a time. Each table access is a read state and then a state
// that uses the entry; the single-port table walk sets how long a request takes.
// After reset and after each active_blocks write a clearing pass over all
// TABLE_BLOCKS entries runs with the request channel stalled.
// A finished result waits in the output register while the next request is
// taken; the block only holds in its final state while that result is stalled.
//
// Top level of the block-table first-fit allocator. Depends on btffa_pkg,
// btffa_ctrl and btffa_datapath.
module block_table_first_fit_allocator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [btffa_pkg::KIND_W-1:0]       i_kind,
    input  logic [btffa_pkg::SIZE_W-1:0]       i_size_bytes,
    input  logic [btffa_pkg::ADDR_W-1:0]       i_address,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [btffa_pkg::STAT_W-1:0]       o_status,
    output logic [btffa_pkg::ADDR_W-1:0]       o_result_address,
    output logic                               o_copy_needed,
    output logic [btffa_pkg::COPY_W-1:0]       o_copy_bytes,
    output logic [btffa_pkg::CNT_OUT_W-1:0]    o_taken_blocks,
    output logic [btffa_pkg::CNT_OUT_W-1:0]    o_spare_blocks,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [btffa_pkg::ADDR_W-1:0]       i_cfg_data
);

    btffa_pkg::t_ctl_cmd cmd;
    btffa_pkg::t_dp_stat stat;

    // config writes go straight into registers, so the port never pushes back
    assign o_cfg_ready = 1'b1;

    btffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    btffa_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_kind),
        .i_size_bytes     (i_size_bytes),
        .i_address        (i_address),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_copy_needed    (o_copy_needed),
        .o_copy_bytes     (o_copy_bytes),
        .o_taken_blocks   (o_taken_blocks),
        .o_spare_blocks   (o_spare_blocks),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

endmodule

// ===== rtl/btffa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on btffa_pkg and the assertion macro header.
`include "block_table_first_fit_allocator_core_macros.svh"

module btffa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [btffa_pkg::STAT_W-1:0]       o_status,
    input logic [btffa_pkg::ADDR_W-1:0]       o_result_address,
    input logic                               o_copy_needed,
    input logic [btffa_pkg::COPY_W-1:0]       o_copy_bytes,
    input logic [btffa_pkg::CNT_OUT_W-1:0]    o_taken_blocks,
    input logic [btffa_pkg::CNT_OUT_W-1:0]    o_spare_blocks
);

    logic [btffa_pkg::CNT_OUT_W:0] total;
    logic                          out_held;
    logic                          out_failed;
    logic                          out_copy;

    assign total = (btffa_pkg::CNT_OUT_W+1)'(o_taken_blocks)
                 + (btffa_pkg::CNT_OUT_W+1)'(o_spare_blocks);
    assign out_held   = o_out_valid && i_out_stall;
    assign out_failed = o_out_valid && (o_status != btffa_pkg::ST_OK);
    assign out_copy   = o_out_valid && o_copy_needed;

    `BTFFA_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_result_address) && $stable(o_status), "stalled result changed")
    `BTFFA_ASSERT(a_fail_clean, out_failed |-> o_result_address == '0 && !o_copy_needed, "failed request carries an address or copy")
    `BTFFA_ASSERT(a_copy_size, out_copy |-> o_copy_bytes != '0 && o_status == btffa_pkg::ST_OK, "copy without a moved allocation")
    `BTFFA_ASSERT(a_count_sum, o_out_valid |-> total <= (btffa_pkg::CNT_OUT_W+1)'(btffa_pkg::TABLE_BLOCKS), "taken plus spare exceeds the table")
    `BTFFA_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_out_valid, "result after reset")

endmodule

bind block_table_first_fit_allocator_core btffa_checker u_btffa_checker (.*);

// ===== test/tb_block_table_first_fit_allocator_core.sv =====
// Self-checking testbench for the block-table first-fit allocator core.
// Depends on btffa_pkg and block_table_first_fit_allocator_core only.
module tb_block_table_first_fit_allocator_core;

    localparam int TABLE_BLOCKS = btffa_pkg::TABLE_BLOCKS;
    localparam int BLOCK_BYTES  = btffa_pkg::BLOCK_BYTES;
    localparam int KIND_W       = btffa_pkg::KIND_W;
    localparam int SIZE_W       = btffa_pkg::SIZE_W;
    localparam int ADDR_W       = btffa_pkg::ADDR_W;
    localparam int STAT_W       = btffa_pkg::STAT_W;
    localparam int COPY_W       = btffa_pkg::COPY_W;
    localparam int CNT_OUT_W    = btffa_pkg::CNT_OUT_W;
    localparam int ACT_W        = btffa_pkg::ACT_W;
    localparam int ENT_TAKEN    = btffa_pkg::ENT_TAKEN;
    localparam int ENT_FIRST    = btffa_pkg::ENT_FIRST;
    localparam int ENT_NEXT     = btffa_pkg::ENT_NEXT;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = btffa_pkg::KIND_ALLOC;
    localparam logic [KIND_W-1:0] KIND_FREE   = btffa_pkg::KIND_FREE;
    localparam logic [KIND_W-1:0] KIND_RESIZE = btffa_pkg::KIND_RESIZE;
    localparam logic [STAT_W-1:0] ST_OK       = btffa_pkg::ST_OK;
    localparam logic [STAT_W-1:0] ST_NOMEM    = btffa_pkg::ST_NOMEM;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = btffa_pkg::ST_BAD_ADDR;
    localparam logic CFG_HEAP_BASE = btffa_pkg::CFG_HEAP_BASE;
    localparam logic CFG_ACTIVE    = btffa_pkg::CFG_ACTIVE;

    // kind value with no operation behind it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int DRAIN_CYCLES = 6000;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    addr;
        logic                 copy;
        logic [COPY_W-1:0]    copy_bytes;
        logic [CNT_OUT_W-1:0] used;
        logic [CNT_OUT_W-1:0] free_n;
    } t_alloc_res;

    // one request waiting for the driver; from_live picks a live allocation
    // and adds addr to it as an offset, drain holds it until all results are back
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                from_live;
        bit                drain;
    } t_alloc_req;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind = '0;
    logic [SIZE_W-1:0]    i_size_bytes = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [ADDR_W-1:0]    o_result_address;
    logic                 o_copy_needed;
    logic [COPY_W-1:0]    o_copy_bytes;
    logic [CNT_OUT_W-1:0] o_taken_blocks;
    logic [CNT_OUT_W-1:0] o_spare_blocks;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    block_table_first_fit_allocator_core dut (.*);

    // shadow of the heap state
    logic [ADDR_W-1:0] heap_base_q;
    int unsigned       active_q;
    logic [2:0]        table_q [TABLE_BLOCKS];
    int unsigned       taken_q;
    int unsigned       free_q;

    t_alloc_res  expected_q [$];
    t_alloc_req  pending_q [$];
    logic [ADDR_W-1:0] live_q [$];   // addresses of allocations held now
    int          errors;
    int unsigned cycles;
    bit          took_req;           // request transaction at last rising edge
    bit          took_cfg;           // config transaction at last rising edge

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- heap shadow ----------------
    function automatic int unsigned live_blocks();
        return (active_q > TABLE_BLOCKS) ? TABLE_BLOCKS : active_q;
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < TABLE_BLOCKS; i++) table_q[i] = 3'b000;
        taken_q = 0;
        free_q  = live_blocks();
        live_q.delete();
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(int unsigned blk);
        return heap_base_q + ADDR_W'(64'(blk) * BLOCK_BYTES);
    endfunction

    function automatic logic [63:0] round_blocks(logic [63:0] bytes);
        return (bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
    endfunction

    function automatic bit first_fit(logic [63:0] need, output int unsigned start);
        int unsigned run;
        run = 0;
        start = 0;
        for (int unsigned i = 0; i < live_blocks(); i++) begin
            if (table_q[i][ENT_TAKEN]) begin
                run = 0;
            end else begin
                if (run == 0) start = i;
                run++;
                if (run == need) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void take_run(int unsigned start, int unsigned cnt);
        for (int unsigned i = 0; i < cnt && start + i < TABLE_BLOCKS; i++) begin
            table_q[start+i] = 3'b000;
            table_q[start+i][ENT_TAKEN] = 1'b1;
            table_q[start+i][ENT_FIRST] = (i == 0);
            table_q[start+i][ENT_NEXT]  = (i + 1 != cnt);
        end
        taken_q += cnt;
        free_q  -= cnt;
    endfunction

    function automatic void release_chain(int unsigned start);
        int unsigned freed;
        logic [2:0]  e;
        freed = 0;
        for (int unsigned i = start; i < live_blocks(); i++) begin
            e = table_q[i];
            table_q[i] = 3'b000;
            freed++;
            if (!e[ENT_NEXT]) break;
        end
        taken_q -= freed;
        free_q  += freed;
    endfunction

    function automatic int unsigned chain_blocks(int unsigned start);
        int unsigned cnt;
        cnt = 0;
        for (int unsigned i = start; i < live_blocks(); i++) begin
            if (table_q[i][ENT_TAKEN]) cnt++;
            if (!table_q[i][ENT_NEXT]) break;
        end
        return cnt;
    endfunction

    // good only for the head block of a taken run inside the active heap
    function automatic bit head_block(logic [ADDR_W-1:0] a, output int unsigned blk);
        logic [ADDR_W-1:0] off;
        off = a - heap_base_q;
        blk = 0;
        if (off % BLOCK_BYTES != 0) return 1'b0;
        if (off / BLOCK_BYTES >= live_blocks()) return 1'b0;
        blk = int'(off / BLOCK_BYTES);
        return table_q[blk][ENT_TAKEN] && table_q[blk][ENT_FIRST];
    endfunction

    function automatic logic [STAT_W-1:0] allocate(logic [SIZE_W-1:0] size,
                                                   output logic [ADDR_W-1:0] a);
        logic [63:0] need;
        int unsigned start;
        a = '0;
        if (size == 0) return ST_NOMEM;
        need = round_blocks(64'(size));
        if (need > live_blocks() || !first_fit(need, start)) return ST_NOMEM;
        take_run(start, int'(need));
        a = addr_of(start);
        return ST_OK;
    endfunction

    // Works out the result of one request and updates the shadow heap.
    function automatic t_alloc_res heap_request(logic [KIND_W-1:0] kind,
                                                logic [SIZE_W-1:0] size,
                                                logic [ADDR_W-1:0] a);
        t_alloc_res        r;
        logic [ADDR_W-1:0] res;
        int unsigned       blk, cur, want, start;
        bit                room;
        r = '0;
        res = '0;
        case (kind)
            KIND_ALLOC: begin
                r.status = allocate(size, res);
            end
            KIND_FREE: begin
                if (head_block(a, blk)) release_chain(blk);
                else r.status = ST_BAD_ADDR;
            end
            KIND_RESIZE: begin
                if (a == 0) begin
                    r.status = allocate(size, res);
                end else if (!head_block(a, blk)) begin
                    r.status = ST_BAD_ADDR;
                end else if (size == 0 || round_blocks(64'(size)) > live_blocks()) begin
                    r.status = ST_NOMEM;
                end else begin
                    cur  = chain_blocks(blk);
                    want = int'(round_blocks(64'(size)));
                    room = 1'b1;
                    if (cur >= want) begin
                        // shrink: cut the tail off and end the chain early
                        if (cur > want) begin
                            release_chain(blk + want);
                            table_q[blk+want-1][ENT_NEXT] = 1'b0;
                        end
                        res = a;
                    end else begin
                        if (64'(blk) + want > live_blocks()) room = 1'b0;
                        for (int unsigned i = blk + cur; room && i < blk + want; i++)
                            if (table_q[i][ENT_TAKEN]) room = 1'b0;
                        if (room) begin
                            for (int unsigned i = blk + cur; i < blk + want; i++) begin
                                table_q[i] = 3'b000;
                                table_q[i][ENT_TAKEN] = 1'b1;
                                table_q[i][ENT_NEXT]  = (i + 1 != blk + want);
                            end
                            table_q[blk+cur-1][ENT_NEXT] = 1'b1;
                            taken_q += want - cur;
                            free_q  -= want - cur;
                            res = a;
                        end else if (first_fit(64'(want), start)) begin
                            take_run(start, want);
                            release_chain(blk);
                            res = addr_of(start);
                            r.copy = 1'b1;
                            r.copy_bytes = COPY_W'(64'(cur) * BLOCK_BYTES);
                        end else begin
                            r.status = ST_NOMEM;
                        end
                    end
                end
            end
            default: r.status = ST_NOMEM;
        endcase
        r.addr   = (r.status == ST_OK) ? res : '0;
        r.used   = CNT_OUT_W'(taken_q);
        r.free_n = CNT_OUT_W'(free_q);
        return r;
    endfunction

    // keep the list of live allocations in step with the shadow heap
    function automatic void track_live(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] a,
                                       t_alloc_res r);
        if (r.status != ST_OK) return;
        if (kind == KIND_FREE || (kind == KIND_RESIZE && a != 0 && r.addr != a))
            foreach (live_q[i])
                if (live_q[i] == a) begin
                    live_q.delete(i);
                    break;
                end
        if (kind == KIND_ALLOC || (kind == KIND_RESIZE && r.addr != a))
            live_q.push_back(r.addr);
    endfunction

    // ---------------- monitor: check results, predict accepted requests ----------------
    always @(posedge i_clk) begin
        t_alloc_res got, want_r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_status, o_result_address, o_copy_needed, o_copy_bytes,
                        o_taken_blocks, o_spare_blocks};
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result transaction, expected none, actual %p",
                             $time, got);
                    errors++;
                end else begin
                    want_r = expected_q.pop_front();
                    if (got.status !== want_r.status) begin
                        $display("%0t status: expected %0d actual %0d",
                                 $time, want_r.status, got.status);
                        errors++;
                    end
                    if (got.addr !== want_r.addr) begin
                        $display("%0t result_address: expected %h actual %h",
                                 $time, want_r.addr, got.addr);
                        errors++;
                    end
                    if (got.copy !== want_r.copy) begin
                        $display("%0t copy_needed: expected %0d actual %0d",
                                 $time, want_r.copy, got.copy);
                        errors++;
                    end
                    if (got.copy_bytes !== want_r.copy_bytes) begin
                        $display("%0t copy_bytes: expected %0d actual %0d",
                                 $time, want_r.copy_bytes, got.copy_bytes);
                        errors++;
                    end
                    if (got.used !== want_r.used) begin
                        $display("%0t taken_blocks: expected %0d actual %0d",
                                 $time, want_r.used, got.used);
                        errors++;
                    end
                    if (got.free_n !== want_r.free_n) begin
                        $display("%0t spare_blocks: expected %0d actual %0d",
                                 $time, want_r.free_n, got.free_n);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want_r = heap_request(i_kind, i_size_bytes, i_address);
                expected_q.push_back(want_r);
                track_live(i_kind, i_address, want_r);
                took_req = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_BASE) begin
                    heap_base_q = i_cfg_data - (i_cfg_data % BLOCK_BYTES);
                end else begin
                    active_q = int'(i_cfg_data[ACT_W-1:0]);
                    clear_heap();
                end
                took_cfg = 1'b1;
            end
        end
    end

    // ---------------- request driver: bursts with random gaps ----------------
    int unsigned burst_left = 4;
    int unsigned gap_left   = 0;
    always @(negedge i_clk) begin
        t_alloc_req        it;
        logic [ADDR_W-1:0] a;
        bit                load;
        load = 1'b0;
        if (i_rst_n && (!i_in_valid || took_req)) begin
            took_req = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || (expected_q.size() == 0 && !i_in_valid))) begin
                it = pending_q.pop_front();
                a = it.addr;
                if (it.from_live && live_q.size() > 0)
                    a = live_q[$urandom_range(0, live_q.size() - 1)] + it.addr;
                i_kind       <= it.kind;
                i_size_bytes <= it.size;
                i_address    <= a;
                load = 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                end
            end
            i_in_valid <= load;
        end
    end

    // ---------------- result stall pattern ----------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cycles[4];
        endcase
    end

    // ---------------- stimulus ----------------
    // checked at the rising edge, after the driver's falling-edge updates settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_q.size() > 0 || i_in_valid || expected_q.size() > 0);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        took_cfg = 1'b0;
        do @(negedge i_clk);
        while (!took_cfg);
        took_cfg = 1'b0;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_req(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] s,
                            logic [ADDR_W-1:0] a, bit live = 0, bit drain = 0);
        t_alloc_req it;
        it.kind = k; it.size = s; it.addr = a; it.from_live = live; it.drain = drain;
        pending_q.push_back(it);
    endtask

    // size of a few blocks, scaled to the active heap
    function automatic logic [SIZE_W-1:0] small_size(int unsigned div);
        int unsigned nb;
        nb = $urandom_range(1, (live_blocks() / div > 1) ? live_blocks() / div : 1);
        return SIZE_W'((nb - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
    endfunction

    task automatic random_phase(int n);
        int unsigned pick;
        logic [ADDR_W-1:0] off;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            // an alloc as the first item of a phase, and a few more items, wait for every result
            off = '0;
            if ($urandom_range(0, 9) == 0)
                off = ($urandom_range(0, 1) != 0) ? ADDR_W'(BLOCK_BYTES)
                                                   : ADDR_W'($urandom_range(1, 4095));
            if (pick < 45)
                push_req(KIND_ALLOC, small_size(4), '0, 0, i == 0 || pick == 0);
            else if (pick < 70)
                push_req(KIND_FREE, $urandom(), off, 1, pick == 50);
            else if (pick < 90)
                push_req(KIND_RESIZE, small_size(3), off, 1);
            else if (pick < 95)
                push_req(KIND_W'($urandom_range(0, 3)), $urandom(),
                         ADDR_W'({$urandom(), $urandom()}), 0);
            else
                push_req(KIND_W'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) != 0) ? '0 : $urandom(), off, 1);
        end
    endtask

    task automatic set_heap(logic [ADDR_W-1:0] base, int unsigned act);
        wait_idle();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_ACTIVE, ADDR_W'(act));
    endtask

    logic [ADDR_W-1:0] b;
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = 1'b0;
        i_cfg_data   = '0;
        errors = 0;
        cycles = 0;
        took_req = 1'b0;
        took_cfg = 1'b0;
        heap_base_q = '0;
        active_q = TABLE_BLOCKS;
        clear_heap();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: 8-block heap placed so that addresses wrap past the top;
        // the low bits of the base write are dropped.
        set_heap(48'hFFFF_FFFF_D07B, 8);
        b = 48'hFFFF_FFFF_D000;
        push_req(KIND_ALLOC, 0, '0);                                   // zero size
        push_req(KIND_ALLOC, 1, '0);                                   // blk 0
        push_req(KIND_ALLOC, 2 * BLOCK_BYTES + 1, '0);                 // blk 1..3
        push_req(KIND_ALLOC, BLOCK_BYTES, '0);                         // blk 4
        push_req(KIND_RESIZE, 2 * BLOCK_BYTES, b);                     // blocked: move
        push_req(KIND_RESIZE, BLOCK_BYTES, b + BLOCK_BYTES);           // shrink
        push_req(KIND_RESIZE, 3 * BLOCK_BYTES, b + BLOCK_BYTES);       // grow in place
        push_req(KIND_FREE, 0, b + 2 * BLOCK_BYTES);                   // not a head
        push_req(KIND_FREE, 0, b + 5);                                 // misaligned
        push_req(KIND_FREE, 0, b + 8 * BLOCK_BYTES);                   // past the heap
        push_req(KIND_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);      // unknown kind
        push_req(KIND_RESIZE, 100, '0);                                // resize as alloc
        push_req(KIND_RESIZE, 0, b + BLOCK_BYTES);                     // zero size
        push_req(KIND_RESIZE, 0, b + 3 * BLOCK_BYTES);                 // bad addr first
        push_req(KIND_ALLOC, 32'hFFFF_FFFF, '0);                       // oversized
        push_req(KIND_RESIZE, 8 * BLOCK_BYTES, b + 4 * BLOCK_BYTES);   // move fails
        push_req(KIND_FREE, 0, b + BLOCK_BYTES, 0, 1);
        push_req(KIND_FREE, 0, b + BLOCK_BYTES);                       // double free
        push_req(KIND_ALLOC, 9 * BLOCK_BYTES, '0);                     // one too many
        push_req(KIND_RESIZE, 32'hFFFF_FFFF, b + 5 * BLOCK_BYTES);     // oversized resize
        push_req(KIND_ALLOC, 8 * BLOCK_BYTES, '0);                     // whole heap, no room
        push_req(KIND_FREE, 0, '0);

        // Random phases over several heap settings, extremes included.
        set_heap(48'hFFFF_FFFF_FFFF, 1);
        random_phase(40);
        set_heap(ADDR_W'({$urandom(), $urandom()}), 16);
        random_phase(70);
        set_heap('0, 64);
        random_phase(60);
        set_heap(ADDR_W'({$urandom(), $urandom()}), TABLE_BLOCKS);
        random_phase(30);
        set_heap(ADDR_W'({$urandom(), $urandom()}), 5);
        random_phase(70);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
